@@ design/sda_pkg.sv @@
// Package for the scaled decimal ALU: widths, op codes, sequencer states,
// the divide-by-ten result type and the power-of-ten table.
// No dependencies.
package sda_pkg;

	localparam int DATA_W          = 64;
	localparam int SHIFT_IN_W      = 5;
	localparam int SHIFT_OUT_W     = 6;
	localparam int OP_W            = 3;
	localparam int DIVIDE_DIGITS_DEF = 9;

	// |a| * 10^31 * 10^18 needs 226 bits; keep headroom for the x8 operand
	localparam int WIDE_W   = 228;
	// quotient of a non-tiny divide stays below 2^63 * 10^6 < 2^83
	localparam int QUO_BITS = 88;
	localparam int CNT_W    = $clog2(QUO_BITS + 1);

	localparam int TINY_EXP    = 6;
	localparam int TINY_ALWAYS = 25;

	typedef enum logic [OP_W-1:0] {
		OP_PASS = 3'd0,
		OP_DIV  = 3'd1,
		OP_MUL  = 3'd2,
		OP_SUB  = 3'd3,
		OP_ADD  = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALIGN,
		S_ADDSUB,
		S_MUL,
		S_DZ_CHECK,
		S_SCALE_NUM,
		S_SCALE_DEN,
		S_LEN_CMP,
		S_LEN_MUL,
		S_SCALE_S,
		S_DIV_INIT,
		S_DIV_STEP,
		S_STRIP,
		S_STRIP_CHK,
		S_STRIP_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] quot;
		logic              rem_zero;
	} div10_res_t;

	function automatic logic [DATA_W-1:0] pow10(input logic [4:0] k);
		case (k)
			5'd0:    return 64'd1;
			5'd1:    return 64'd10;
			5'd2:    return 64'd100;
			5'd3:    return 64'd1000;
			5'd4:    return 64'd10000;
			5'd5:    return 64'd100000;
			5'd6:    return 64'd1000000;
			5'd7:    return 64'd10000000;
			5'd8:    return 64'd100000000;
			5'd9:    return 64'd1000000000;
			5'd10:   return 64'd10000000000;
			5'd11:   return 64'd100000000000;
			5'd12:   return 64'd1000000000000;
			5'd13:   return 64'd10000000000000;
			5'd14:   return 64'd100000000000000;
			5'd15:   return 64'd1000000000000000;
			5'd16:   return 64'd10000000000000000;
			5'd17:   return 64'd100000000000000000;
			5'd18:   return 64'd1000000000000000000;
			default: return 64'd0;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (64'd0 - v) : v;
	endfunction

	// |B| / 10^bs <= 1e-6, exact
	function automatic logic tiny_divisor(input logic [DATA_W-1:0] bmag,
	                                      input logic [SHIFT_IN_W-1:0] bs);
		logic [SHIFT_IN_W-1:0] e;
		e = bs - SHIFT_IN_W'(TINY_EXP);
		if (bs < SHIFT_IN_W'(TINY_EXP))
			return bmag == 64'd0;
		else if (bs >= SHIFT_IN_W'(TINY_ALWAYS))
			return 1'b1;
		else
			return bmag <= pow10(e);
	endfunction

endpackage

@@ design/sda_adder.sv @@
// Shared wide adder/subtractor of the scaled decimal ALU.
// Carry out high on a subtract means a >= b. No dependencies.
module sda_adder #(
	parameter int W = 228
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	assign {carry, sum} = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);

endmodule

@@ design/sda_div10.sv @@
// Iterative divide-by-ten of a 64-bit magnitude, eight bits a cycle.
// Depends on sda_pkg.
module sda_div10 import sda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	output logic              done,
	output div10_res_t        res
);

	localparam int STEP_BITS = 8;
	localparam int STEPS     = DATA_W / STEP_BITS;
	localparam int CW        = $clog2(STEPS);

	logic [DATA_W-1:0]    n_q;
	logic [3:0]           rem_q;
	logic [3:0]           rem_d;
	logic [STEP_BITS-1:0] qbits;
	logic [CW-1:0]        cnt_q;
	logic                 run_q;
	logic                 done_q;

	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, n_q[DATA_W-1-i]};
			if (t >= 5'd10) begin
				r = 4'(t - 5'd10);
				qbits[STEP_BITS-1-i] = 1'b1;
			end else begin
				r = t[3:0];
			end
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			n_q   <= {n_q[DATA_W-STEP_BITS-1:0], qbits};
			rem_q <= rem_d;
		end
	end

	assign done         = done_q;
	assign res.quot     = n_q;
	assign res.rem_zero = (rem_q == 4'd0);

endmodule

@@ design/scaled_decimal_alu.sv @@
// Scaled decimal ALU: pass, add, subtract, multiply and divide on
// 64-bit scaled integers with decimal place counts, trailing zeros stripped.
// Depends on sda_pkg, sda_adder and sda_div10.
//
// A word is taken when start is high and busy is low; busy stays high until
// the result is out. The result appears for exactly one cycle with done high
// and the receiver cannot stall it. All wide arithmetic runs on one 228-bit
// adder under a sequencer, one operation a cycle, so the latency depends on
// the operands. Add and subtract scale the operand with fewer places by
// 10^|a_shift - b_shift|, then add; multiply runs 64 shift-and-add steps;
// divide, unless it is by zero, scales |a| by 10^b_shift and |b| by
// 10^a_shift, finds the digit count L of the quotient, scales |a| by
// 10^(DIVIDE_DIGITS - L) and runs an 88-step restoring long division. Each
// zero stripped (at most 18) costs a trial divide by ten in the divide-by-ten
// unit that handles eight bits a cycle; it stops at a remainder or shift 0.
// done is high in the first cycle with busy low; a new word can be taken in it.
module scaled_decimal_alu import sda_pkg::*; #(
	parameter int DIVIDE_DIGITS = DIVIDE_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [OP_W-1:0]               op,
	input  logic signed [DATA_W-1:0]      a_value,
	input  logic [SHIFT_IN_W-1:0]         a_shift,
	input  logic signed [DATA_W-1:0]      b_value,
	input  logic [SHIFT_IN_W-1:0]         b_shift,
	output logic                          done,
	output logic signed [DATA_W-1:0]      result_value,
	output logic [SHIFT_OUT_W-1:0]        result_shift,
	output logic                          divide_by_zero
);

	localparam int LEN_W = $clog2(DIVIDE_DIGITS + 1);

	state_t state_q, state_d;

	logic [WIDE_W-1:0]      x_q, y_q, r_q;
	logic [DATA_W-1:0]      a_q, b_q, q_q, v_q, m_q;
	logic [SHIFT_IN_W-1:0]  as_q, bs_q;
	logic [SHIFT_OUT_W-1:0] sh_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [LEN_W-1:0]       len_q;
	logic                   scale_a_q, neg_q, sneg_q, dz_q;

	logic [DATA_W-1:0]      res_value_q;
	logic [SHIFT_OUT_W-1:0] res_shift_q;
	logic                   res_dz_q, done_q;

	logic [WIDE_W-1:0]      add_a, add_b, add_sum, src10, rs;
	logic                   add_sub, add_carry;
	logic                   tiny, d10_start, d10_done;
	div10_res_t             d10_res;
	logic [SHIFT_OUT_W-1:0] s_val;

	sda_adder #(.W(WIDE_W)) u_adder (
		.a     (add_a),
		.b     (add_b),
		.sub   (add_sub),
		.sum   (add_sum),
		.carry (add_carry)
	);

	sda_div10 u_div10 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (d10_start),
		.dividend (m_q),
		.done     (d10_done),
		.res      (d10_res)
	);

	assign tiny  = tiny_divisor(mag64(b_q), bs_q);
	assign rs    = {r_q[WIDE_W-2:0], x_q[QUO_BITS-1]};
	assign s_val = SHIFT_OUT_W'(DIVIDE_DIGITS) - SHIFT_OUT_W'(len_q);

	// operand select for the shared adder; times ten is (x << 3) + (x << 1)
	always_comb begin
		add_sub = 1'b0;
		src10   = x_q;
		case (state_q)
			S_ALIGN:     src10 = scale_a_q ? x_q : y_q;
			S_SCALE_DEN: src10 = y_q;
			S_LEN_MUL:   src10 = r_q;
			default:     src10 = x_q;
		endcase
		add_a = {src10[WIDE_W-4:0], 3'b000};
		add_b = {src10[WIDE_W-2:0], 1'b0};
		case (state_q)
			S_ADDSUB: begin
				add_a   = x_q;
				add_b   = y_q;
				add_sub = neg_q;
			end
			S_MUL: begin
				add_a = x_q;
				add_b = b_q[0] ? y_q : '0;
			end
			S_LEN_CMP: begin
				add_a   = x_q;
				add_b   = r_q;
				add_sub = 1'b1;
			end
			S_DIV_STEP: begin
				add_a   = rs;
				add_b   = y_q;
				add_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		d10_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						OP_DIV:         state_d = S_DZ_CHECK;
						OP_MUL:         state_d = S_MUL;
						OP_SUB, OP_ADD: state_d = S_ALIGN;
						default:        state_d = S_STRIP;
					endcase
				end
			end
			S_ALIGN:     if (cnt_q == '0) state_d = S_ADDSUB;
			S_ADDSUB:    state_d = S_STRIP;
			S_MUL:       if (cnt_q == '0) state_d = S_STRIP;
			S_DZ_CHECK:  state_d = tiny ? S_STRIP : S_SCALE_NUM;
			S_SCALE_NUM: if (cnt_q == '0) state_d = S_SCALE_DEN;
			S_SCALE_DEN: if (cnt_q == '0) state_d = S_LEN_CMP;
			S_LEN_CMP: begin
				if (len_q != LEN_W'(DIVIDE_DIGITS) && add_carry)
					state_d = S_LEN_MUL;
				else
					state_d = S_SCALE_S;
			end
			S_LEN_MUL:   state_d = S_LEN_CMP;
			S_SCALE_S:   if (cnt_q == '0) state_d = S_DIV_INIT;
			S_DIV_INIT:  state_d = S_DIV_STEP;
			S_DIV_STEP:  if (cnt_q == '0) state_d = S_STRIP;
			S_STRIP:     state_d = S_STRIP_CHK;
			S_STRIP_CHK: begin
				if (sh_q == '0 || m_q == '0) begin
					state_d = S_DONE;
				end else begin
					d10_start = 1'b1;
					state_d   = S_STRIP_WAIT;
				end
			end
			S_STRIP_WAIT: begin
				if (d10_done)
					state_d = d10_res.rem_zero ? S_STRIP_CHK : S_DONE;
			end
			S_DONE:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == S_DONE);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					a_q  <= a_value;
					b_q  <= b_value;
					as_q <= a_shift;
					bs_q <= b_shift;
					dz_q <= 1'b0;
					// subtract flag rides in neg_q until the divide needs it
					neg_q <= (op == OP_SUB);
					case (op)
						OP_MUL: begin
							x_q   <= '0;
							y_q   <= WIDE_W'(a_value);
							cnt_q <= CNT_W'(DATA_W);
							sh_q  <= {1'b0, a_shift} + {1'b0, b_shift};
						end
						OP_SUB, OP_ADD: begin
							x_q <= WIDE_W'(a_value);
							y_q <= WIDE_W'(b_value);
							if (a_shift < b_shift) begin
								scale_a_q <= 1'b1;
								cnt_q     <= CNT_W'(b_shift - a_shift);
								sh_q      <= {1'b0, b_shift};
							end else begin
								scale_a_q <= 1'b0;
								cnt_q     <= CNT_W'(a_shift - b_shift);
								sh_q      <= {1'b0, a_shift};
							end
						end
						OP_DIV: ;
						default: begin
							v_q  <= b_value;
							sh_q <= {1'b0, b_shift};
						end
					endcase
				end
			end
			S_ALIGN: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					if (scale_a_q)
						x_q <= WIDE_W'(add_sum[DATA_W-1:0]);
					else
						y_q <= WIDE_W'(add_sum[DATA_W-1:0]);
				end
			end
			S_ADDSUB: v_q <= add_sum[DATA_W-1:0];
			S_MUL: begin
				if (cnt_q == '0) begin
					v_q <= x_q[DATA_W-1:0];
				end else begin
					x_q   <= WIDE_W'(add_sum[DATA_W-1:0]);
					y_q   <= WIDE_W'({y_q[DATA_W-2:0], 1'b0});
					b_q   <= {1'b0, b_q[DATA_W-1:1]};
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_DZ_CHECK: begin
				if (tiny) begin
					v_q  <= a_q;
					sh_q <= {1'b0, as_q};
					dz_q <= 1'b1;
				end else begin
					x_q   <= WIDE_W'(mag64(a_q));
					y_q   <= WIDE_W'(mag64(b_q));
					neg_q <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
					cnt_q <= CNT_W'(bs_q);
				end
			end
			S_SCALE_NUM: begin
				if (cnt_q == '0) begin
					cnt_q <= CNT_W'(as_q);
				end else begin
					x_q   <= add_sum;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_SCALE_DEN: begin
				if (cnt_q == '0) begin
					r_q   <= y_q;
					len_q <= '0;
				end else begin
					y_q   <= add_sum;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_LEN_CMP: begin
				if (len_q != LEN_W'(DIVIDE_DIGITS) && add_carry) begin
					len_q <= len_q + 1'b1;
				end else begin
					sh_q  <= s_val;
					cnt_q <= CNT_W'(s_val);
				end
			end
			S_LEN_MUL: r_q <= add_sum;
			S_SCALE_S: begin
				if (cnt_q != '0) begin
					x_q   <= add_sum;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_DIV_INIT: begin
				r_q   <= x_q >> QUO_BITS;
				q_q   <= '0;
				cnt_q <= CNT_W'(QUO_BITS);
			end
			S_DIV_STEP: begin
				if (cnt_q == '0) begin
					v_q <= neg_q ? (64'd0 - q_q) : q_q;
				end else begin
					r_q   <= add_carry ? add_sum : rs;
					q_q   <= {q_q[DATA_W-2:0], add_carry};
					x_q   <= {x_q[WIDE_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_STRIP: begin
				m_q    <= mag64(v_q);
				sneg_q <= v_q[DATA_W-1];
			end
			S_STRIP_CHK: if (m_q == '0) sh_q <= '0;
			S_STRIP_WAIT: begin
				if (d10_done && d10_res.rem_zero) begin
					m_q  <= d10_res.quot;
					sh_q <= sh_q - 1'b1;
				end
			end
			S_DONE: begin
				res_value_q <= sneg_q ? (64'd0 - m_q) : m_q;
				res_shift_q <= sh_q;
				res_dz_q    <= dz_q;
			end
			default: ;
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign result_value   = res_value_q;
	assign result_shift   = res_shift_q;
	assign divide_by_zero = res_dz_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DONE))
		else $error("done without a finished result");

	a_zero_shift: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_value == 0 |-> result_shift == '0)
		else $error("zero result kept decimal places");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV_STEP |-> r_q < y_q)
		else $error("division remainder not below divisor");

endmodule
